@@ sv/apjf_pkg.sv @@
// Shared types, constants and helpers for the audio prefill jitter FIFO.
// Used by the controller, the datapath, the top level and the port checker.
package apjf_pkg;

  localparam int DEPTH_FRAMES = 4096;
  localparam int MAX_BURST    = 64;
  localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
  localparam int LEVEL_W      = $clog2(DEPTH_FRAMES + 1);
  localparam int CNT_W        = 7;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int STATUS_W     = 3;

  localparam logic [CFG_W-1:0] START_LEVEL_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HIGH_LEVEL_RST  = CFG_W'(3584);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEVEL = 1'b0,
    REG_HIGH_LEVEL  = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_PLAYED   = 3'd2,
    ST_UNDERRUN = 3'd3,
    ST_PREFILL  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SILENCE,
    S_PLAY_RD,
    S_PLAY_LD
  } state_t;

  typedef struct packed {
    logic start_write;
    logic start_read;
    logic emit_silence;
    logic mem_read;
    logic load_played;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic play_ok;
    logic burst_last;
    logic rd_last;
  } dp_stat_t;

  function automatic logic [SAMPLE_W-1:0] byte_swap(input logic [SAMPLE_W-1:0] w);
    byte_swap = {w[7:0], w[15:8]};
  endfunction

endpackage

@@ sv/apjf_ctrl.sv @@
// Controller state machine of the audio prefill jitter FIFO.
// Depends on apjf_pkg; drives commands to apjf_dp and reads its status.
module apjf_ctrl
  import apjf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       func,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (!func) begin
            cmd.start_write = 1'b1;
          end else begin
            cmd.start_read = 1'b1;
            state_next     = stat.play_ok ? S_PLAY_RD : S_SILENCE;
          end
        end
      end
      S_SILENCE: begin
        if (stat.out_free) begin
          cmd.emit_silence = 1'b1;
          if (stat.burst_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_PLAY_RD: begin
        if (stat.out_free) begin
          cmd.mem_read = 1'b1;
          state_next   = S_PLAY_LD;
        end
      end
      S_PLAY_LD: begin
        cmd.load_played = 1'b1;
        state_next      = stat.rd_last ? S_IDLE : S_PLAY_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/apjf_dp.sv @@
// Datapath of the audio prefill jitter FIFO: frame memory, pointers, fill level,
// configuration registers, burst counter and output register. Depends on apjf_pkg.
module apjf_dp
  import apjf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [SAMPLE_W-1:0]  left_raw,
  input  logic [SAMPLE_W-1:0]  right_raw,
  input  logic [CNT_W-1:0]     frame_count,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SAMPLE_W-1:0]  out_left,
  output logic [SAMPLE_W-1:0]  out_right,
  output logic                 out_last
);

  logic [2*SAMPLE_W-1:0] frame_mem [DEPTH_FRAMES];
  logic [2*SAMPLE_W-1:0] rdata;
  logic                  rd_last;

  logic [CFG_W-1:0]   start_level;
  logic [CFG_W-1:0]   high_level;
  logic [ADDR_W-1:0]  rptr;
  logic [ADDR_W-1:0]  wptr;
  logic [LEVEL_W-1:0] fill;
  logic               playing;
  logic [CNT_W-1:0]   burst_cnt;
  status_t            burst_status;

  logic [CNT_W-1:0]   req_n;
  logic               write_ok;
  logic               underrun;
  logic               prefill;
  logic               out_load;

  always_comb begin
    req_n = frame_count;
    if (frame_count == '0) begin
      req_n = CNT_W'(1);
    end else if (frame_count > CNT_W'(MAX_BURST)) begin
      req_n = CNT_W'(MAX_BURST);
    end
  end

  assign write_ok = ({1'b0, fill} < {1'b0, high_level}) &&
                    (fill < LEVEL_W'(DEPTH_FRAMES));
  assign underrun = fill < LEVEL_W'(req_n);
  assign prefill  = !playing && ({1'b0, fill} < {1'b0, start_level});
  assign out_load = cmd.start_write || cmd.emit_silence || cmd.load_played;

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.play_ok    = !underrun && !prefill;
  assign stat.burst_last = burst_cnt == CNT_W'(1);
  assign stat.rd_last    = rd_last;

  always_ff @(posedge clk) begin
    if (cmd.start_write && write_ok) begin
      frame_mem[wptr] <= {byte_swap(left_raw), byte_swap(right_raw)};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rdata   <= frame_mem[rptr];
      rd_last <= burst_cnt == CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= START_LEVEL_RST;
      high_level  <= HIGH_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_LEVEL: start_level <= cfg_data;
        REG_HIGH_LEVEL:  high_level  <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr         <= '0;
      wptr         <= '0;
      fill         <= '0;
      playing      <= 1'b0;
      burst_cnt    <= '0;
      burst_status <= ST_UNDERRUN;
    end else begin
      if (cmd.start_write && write_ok) begin
        wptr <= (wptr == ADDR_W'(DEPTH_FRAMES - 1)) ? '0 : wptr + ADDR_W'(1);
        fill <= fill + LEVEL_W'(1);
      end
      if (cmd.start_read) begin
        burst_cnt    <= req_n;
        burst_status <= underrun ? ST_UNDERRUN : ST_PREFILL;
        if (!underrun && !prefill) begin
          playing <= 1'b1;
          fill    <= fill - LEVEL_W'(req_n);
        end
      end
      if (cmd.emit_silence || cmd.mem_read) begin
        burst_cnt <= burst_cnt - CNT_W'(1);
      end
      if (cmd.mem_read) begin
        rptr <= (rptr == ADDR_W'(DEPTH_FRAMES - 1)) ? '0 : rptr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_write) begin
      out_status <= write_ok ? ST_STORED : ST_REFUSED;
      out_left   <= '0;
      out_right  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_silence) begin
      out_status <= burst_status;
      out_left   <= '0;
      out_right  <= '0;
      out_last   <= burst_cnt == CNT_W'(1);
    end else if (cmd.load_played) begin
      out_status <= ST_PLAYED;
      out_left   <= rdata[2*SAMPLE_W-1:SAMPLE_W];
      out_right  <= rdata[SAMPLE_W-1:0];
      out_last   <= rd_last;
    end
  end

endmodule

@@ sv/audio_prefill_jitter_fifo_top.sv @@
// Top level of the audio prefill jitter FIFO: joins apjf_ctrl and apjf_dp.
// Depends on apjf_pkg.
//
// Usage: the input channel (in_valid/in_ready) takes one word per item. With
// func low it carries one stereo frame in big-endian byte order; the block
// swaps the bytes, stores the frame if the fill level is below high_level and
// the depth, and answers one word with status stored or refused. With func
// high it asks for a burst of frame_count frames (zero counts as one, above 64
// saturates to 64) and answers one word per frame: played frames, underrun
// silence or prefill silence, with last set on the final word of the item.
// Latency: a write answers in the cycle after it is taken, and a new write can
// be taken every cycle while the receiver keeps up. A silent burst gives one
// word per cycle while the receiver keeps up; a played burst reads each frame
// in PLAY_RD and loads it in PLAY_LD. No item is taken during a burst.
// The configuration channel (cfg_valid/cfg_ready) is always ready; index 0 is
// start_level and index 1 is high_level. Reset empties the FIFO, clears the
// playback latch and restores the register defaults; the frame memory itself
// is not cleared. When out_ready is low the output word holds and the block
// stops taking input until the word is taken.
module audio_prefill_jitter_fifo_top
  import apjf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [SAMPLE_W-1:0]        left_raw,
  input  logic [SAMPLE_W-1:0]        right_raw,
  input  logic [CNT_W-1:0]           frame_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [SAMPLE_W-1:0] left_sample,
  output logic signed [SAMPLE_W-1:0] right_sample,
  output logic                       last
);

  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic [SAMPLE_W-1:0]  out_left;
  logic [SAMPLE_W-1:0]  out_right;

  assign cfg_ready    = 1'b1;
  assign left_sample  = $signed(out_left);
  assign right_sample = $signed(out_right);

  apjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  apjf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_raw    (left_raw),
    .right_raw   (right_raw),
    .frame_count (frame_count),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_status  (status),
    .out_left    (out_left),
    .out_right   (out_right),
    .out_last    (last)
  );

endmodule

@@ sv/apjf_chk.sv @@
// Port checker for the audio prefill jitter FIFO, bound to the top level.
// Depends on apjf_pkg; sees the top-level ports only.
module apjf_chk
  import apjf_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       func,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [STATUS_W-1:0]        status,
  input logic signed [SAMPLE_W-1:0] left_sample,
  input logic signed [SAMPLE_W-1:0] right_sample,
  input logic                       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("Output word changed while stalled.");

  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func |=>
      out_valid && last && (status == ST_STORED || status == ST_REFUSED))
    else $error("Write did not answer with a single stored or refused word.");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PLAYED |-> left_sample == '0 && right_sample == '0)
    else $error("Nonzero samples on a word that is not a played frame.");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func |=> !in_ready)
    else $error("Input taken while a burst is in progress.");

endmodule

bind audio_prefill_jitter_fifo_top apjf_chk u_apjf_chk (.*);
